// File: design/hufd_pkg.sv
package hufd_pkg;

    localparam int IDX_W  = 9;
    localparam int SYM_W  = 8;
    localparam int SYM_MSB = 7;

    // input tdata layout, lowest bit first
    localparam int IN_IDX_LSB   = 0;
    localparam int IN_LEAF_BIT  = 9;
    localparam int IN_SYM_LSB   = 10;
    localparam int IN_LEFT_LSB  = 18;
    localparam int IN_RIGHT_LSB = 27;
    localparam int IN_CODE_BIT  = 36;
    localparam int IN_TDATA_W   = 40;

    localparam int OUT_TDATA_W  = 8;

    // item kinds carried on tuser
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_DECODE = 1'b1;

    typedef struct packed {
        logic               leaf;
        logic [SYM_MSB:0]   sym;
        logic [IDX_W-1:0]   left;
        logic [IDX_W-1:0]   right;
    } t_node;

    localparam int NODE_W = $bits(t_node);

    typedef struct packed {
        logic               kind;
        logic [IDX_W-1:0]   idx;
        t_node              node;
        logic               code_bit;
        logic               last;
    } t_item;

    typedef struct packed {
        logic [SYM_W-1:0]   sym;
        logic               sym_valid;
        logic               done;
    } t_result;

endpackage

// File: design/hufd_ram.sv
module hufd_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/hufd_front.sv
module hufd_front #(
    parameter int TABLE_DEPTH = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [hufd_pkg::IN_TDATA_W-1:0]     i_data,
    input  logic                                i_kind,
    input  logic                                i_last,
    output logic                                o_item_valid,
    output hufd_pkg::t_item                     o_item,
    input  logic                                i_item_pop
);

    localparam int QD = 4;
    localparam int PW = $clog2(QD);

    hufd_pkg::t_item r_q [QD];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [PW:0]     r_count;

    hufd_pkg::t_item n_item;
    logic            w_accept;
    logic            w_push;

    always_comb begin
        n_item.kind       = i_kind;
        n_item.idx        = i_data[hufd_pkg::IN_IDX_LSB +: hufd_pkg::IDX_W];
        n_item.node.leaf  = i_data[hufd_pkg::IN_LEAF_BIT];
        n_item.node.sym   = i_data[hufd_pkg::IN_SYM_LSB +: hufd_pkg::SYM_W];
        n_item.node.left  = i_data[hufd_pkg::IN_LEFT_LSB +: hufd_pkg::IDX_W];
        n_item.node.right = i_data[hufd_pkg::IN_RIGHT_LSB +: hufd_pkg::IDX_W];
        n_item.code_bit   = i_data[hufd_pkg::IN_CODE_BIT];
        n_item.last       = i_last;
    end

    assign o_ready  = (r_count != (PW+1)'(QD));
    assign w_accept = i_valid && o_ready;
    // a write beyond the table is dropped here
    assign w_push   = w_accept && ((i_kind == hufd_pkg::KIND_DECODE)
                                   || (32'(n_item.idx) < TABLE_DEPTH));

    assign o_item_valid = (r_count != '0);
    assign o_item       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_item_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, i_item_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: design/hufd_back.sv
module hufd_back #(
    parameter int TABLE_DEPTH = 512
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_item_valid,
    input  hufd_pkg::t_item     i_item,
    output logic                o_item_pop,
    output logic                o_res_valid,
    output hufd_pkg::t_result   o_res,
    input  logic                i_res_ready
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // copy of the root entry and the cached entry of the node being walked
    hufd_pkg::t_node             r_root;
    logic                        r_cur_root;
    hufd_pkg::t_node             r_cur_ent;
    logic [hufd_pkg::IDX_W-1:0]  r_cur_idx;

    // resolve stage: one decode bit waiting on its table read or holding a result
    logic                        r_b_valid;
    logic                        r_b_rd;
    logic [hufd_pkg::IDX_W-1:0]  r_b_idx;
    logic                        r_b_last;
    logic                        r_b_has;
    logic [hufd_pkg::SYM_W-1:0]  r_b_sym;
    logic                        r_b_sval;

    logic                        r_out_valid;
    hufd_pkg::t_result           r_out;

    logic [hufd_pkg::NODE_W-1:0] w_rdata;
    hufd_pkg::t_node             w_rd_node;
    hufd_pkg::t_result           w_b_res;
    logic                        w_b_has;
    logic                        w_stall;
    logic                        w_adv;
    logic                        w_pop;
    logic                        w_is_wr;
    logic                        w_is_dec;
    logic                        w_eff_root;
    hufd_pkg::t_node             w_eff_ent;
    logic [hufd_pkg::IDX_W-1:0]  w_eff_idx;
    hufd_pkg::t_node             w_walk_ent;
    logic [hufd_pkg::IDX_W-1:0]  w_next;
    logic                        w_next_ok;
    logic                        w_re;
    hufd_pkg::t_node             n_cur_ent;

    assign w_rd_node = hufd_pkg::t_node'(w_rdata);

    always_comb begin
        if (r_b_rd) begin
            w_b_has           = w_rd_node.leaf || r_b_last;
            w_b_res.sym       = w_rd_node.leaf ? w_rd_node.sym : '0;
            w_b_res.sym_valid = w_rd_node.leaf;
        end else begin
            w_b_has           = r_b_has;
            w_b_res.sym       = r_b_sym;
            w_b_res.sym_valid = r_b_sval;
        end
        w_b_res.done = r_b_last;
    end

    assign w_stall = r_b_valid && w_b_has && r_out_valid && !i_res_ready;
    assign w_adv   = !w_stall;
    assign w_pop   = w_adv && i_item_valid;
    assign w_is_wr  = w_pop && (i_item.kind == hufd_pkg::KIND_WRITE);
    assign w_is_dec = w_pop && (i_item.kind == hufd_pkg::KIND_DECODE);

    // walker position after every bit handed over so far
    always_comb begin
        if (r_b_valid && r_b_rd) begin
            w_eff_root = r_b_last || w_rd_node.leaf;
            w_eff_ent  = w_rd_node;
            w_eff_idx  = r_b_idx;
        end else begin
            w_eff_root = r_cur_root;
            w_eff_ent  = r_cur_ent;
            w_eff_idx  = r_cur_idx;
        end
        w_walk_ent = w_eff_root ? r_root : w_eff_ent;
        w_next     = i_item.code_bit ? w_walk_ent.right : w_walk_ent.left;
        w_next_ok  = (32'(w_next) < TABLE_DEPTH);
        w_re       = w_is_dec && !r_root.leaf && w_next_ok;

        n_cur_ent = w_eff_ent;
        if (w_is_wr && !w_eff_root && (i_item.idx == w_eff_idx)) begin
            n_cur_ent = i_item.node;
        end
    end

    hufd_ram #(
        .WIDTH (hufd_pkg::NODE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_is_wr),
        .i_waddr (AW'(i_item.idx)),
        .i_wdata (i_item.node),
        .i_re    (w_re),
        .i_raddr (AW'(w_next)),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_is_wr && (i_item.idx == '0)) begin
                r_root <= i_item.node;
            end
            r_cur_ent <= n_cur_ent;
            r_cur_idx <= w_eff_idx;
            r_b_rd    <= w_re;
            r_b_idx   <= w_next;
            r_b_last  <= i_item.last;
            r_b_has   <= r_root.leaf || i_item.last;
            r_b_sym   <= r_root.leaf ? r_root.sym : '0;
            r_b_sval  <= r_root.leaf;
            if (r_b_valid && w_b_has) begin
                r_out <= w_b_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_root  <= 1'b1;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            // a decode bit sends the walker home unless its read resolves it later
            r_cur_root <= w_is_dec ? 1'b1 : w_eff_root;
            r_b_valid  <= w_is_dec;
            if (r_b_valid && w_b_has) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_item_pop  = w_pop;
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// File: design/huffman_tree_bit_decoder.sv
// Huffman decoder that walks a code tree held in an on-chip node table.
// Input stream (s_axis): tuser selects the item kind, 0 writes one table
// entry (index, leaf flag, symbol, left and right child), 1 decodes one code
// bit, most significant bit of the packed stream first; tlast marks the final
// bit of a stream. Node 0 is the root. Writes beyond the table are dropped.
// Output stream (m_axis): tdata is the symbol, tuser says a symbol was
// completed, tlast marks the result of a stream's last bit. Bits that end no
// symbol and are not last give no transfer.
// Throughput is one item per cycle unless a result waits in the resolve stage
// while the output register is full and the receiver stalls: the child index
// read from the table feeds the next table address through one registered read port.
// An input transfer enters the input queue, its table read is issued when it
// leaves the queue, and the output register loads from the resolve stage.
// Reset puts the walker at the root and empties queue and output; the table
// keeps its contents and must be loaded before decoding. When the receiver
// stalls, the result holds in the output register and the walker keeps going
// until a second result is waiting; then the queue fills and s_axis_tready
// drops.
module huffman_tree_bit_decoder #(
    parameter int TABLE_DEPTH = 512
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // node_index, node_is_leaf, node_symbol, left_child, right_child,
    // code_bit, zero fill
    input  logic [hufd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // action
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // symbol
    output logic [hufd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // symbol_valid
    output logic                                m_axis_tuser,
    output logic                                m_axis_tlast
);

    logic              w_q_valid;
    hufd_pkg::t_item   w_q_item;
    logic              w_pop;
    hufd_pkg::t_result w_res;

    hufd_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_data       (s_axis_tdata),
        .i_kind       (s_axis_tuser),
        .i_last       (s_axis_tlast),
        .o_item_valid (w_q_valid),
        .o_item       (w_q_item),
        .i_item_pop   (w_pop)
    );

    hufd_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (w_q_valid),
        .i_item       (w_q_item),
        .o_item_pop   (w_pop),
        .o_res_valid  (m_axis_tvalid),
        .o_res        (w_res),
        .i_res_ready  (m_axis_tready)
    );

    assign m_axis_tdata = w_res.sym;
    assign m_axis_tuser = w_res.sym_valid;
    assign m_axis_tlast = w_res.done;

    // a transfer without a symbol only ever closes a stream
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("result without symbol and without end of stream");

    // the queue only refuses input when it holds items for the walker
    a_full_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> w_q_valid)
        else $error("input stalled with an empty queue");

    // a new result comes from a decode bit taken from the queue and passed through the resolve stage
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_pop, 2))
        else $error("result appeared without a queued item");

    // nothing leaves the queue while the walker is blocked on a waiting result
    a_pop_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while receiver stalled");

endmodule
